// ===== hw/rtl/afdv_pkg.sv =====
// Shared types and constants for the AUROC/fold vector block.
// No dependencies.
package afdv_pkg;

    typedef struct packed {
        logic signed [31:0] sample_value;
        logic               in_group;
        logic [23:0]        column_scale;
        logic               last_element;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] fold_ratio;
        logic [16:0]        auroc_value;
        logic               saturated;
    } t_out_word;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCALE,
        ST_SCAN_RD,
        ST_SCAN,
        ST_STORE,
        ST_MEAN,
        ST_FOLD,
        ST_AUROC,
        ST_EMIT
    } t_state;

    localparam logic signed [47:0] SCALED_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] SCALED_MIN = 48'sh8000_0000_0000;
    localparam logic [16:0]        AUROC_ONE  = 17'd65536;

endpackage

// ===== hw/rtl/auroc_fold_dense_vector.sv =====
// Top level of the AUROC/fold vector block.
// Depends on afdv_pkg, afdv_front, afdv_back.
//
// Use: raise start with i_word while busy is low to hand in one element.
// Elements queue in a two-word buffer; the back end takes one at a time.
// An element passes through the idle state, a pass of the shared bit-serial divider
// for scaling (none for a zero value or zero scale), a read and a compare per element
// already stored in the vector memory (single read port scan), and a final read
// and store to finish the scan. On the element marked last, the block works out
// the means, the fold and the AUROC with up to four divider passes
// and shows one result word on o_result for one cycle
// with o_strobe high. The receiver cannot stall; the result is simply taken.
// norm_offset is written on i_cfg_valid/o_cfg_ready; the user must write it
// only while the block is idle, which the block itself does not enforce. Reset
// clears counts, sums, score and flags and sets norm_offset to 1.0; the vector
// memory is not cleared, as only entries of the current vector are read.
module auroc_fold_dense_vector #(
    parameter int MAX_ELEMENTS = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  afdv_pkg::t_in_word  i_word,
    output logic                o_strobe,
    output afdv_pkg::t_out_word o_result,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [31:0]         i_cfg_data
);
    logic r_norm_set;
    logic [31:0] r_norm;
    logic q_full, q_valid, q_pop, b_idle;
    afdv_pkg::t_in_word q_word;

    assign busy = q_full;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_norm <= 32'd65536;
        else if (i_cfg_valid) r_norm <= i_cfg_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_norm_set <= 1'b0;
        else if (i_cfg_valid) r_norm_set <= 1'b1;
    end

    afdv_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(start && !busy), .i_word(i_word),
        .i_pop(q_pop), .o_full(q_full), .o_valid(q_valid), .o_word(q_word)
    );

    afdv_back #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(q_valid), .i_word(q_word),
        .i_norm(r_norm), .o_pop(q_pop), .o_idle(b_idle), .o_strobe(o_strobe),
        .o_result(o_result)
    );

`ifndef SYNTHESIS
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid) else $error("pop from empty queue");
    a_idle_no_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe) else $error("double result strobe");
    a_cfg_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |=> r_norm_set && r_norm == $past(i_cfg_data))
        else $error("config write lost");
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        b_idle |-> !q_valid) else $error("idle with queued word");
`endif
endmodule

// ===== hw/rtl/afdv_div.sv =====
// Shared restoring divider, one quotient bit per cycle, unsigned.
// No dependencies.
module afdv_div (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_go,
    input  logic [127:0]  i_num,
    input  logic [63:0]   i_den,
    output logic          o_busy,
    output logic          o_done,
    output logic [127:0]  o_quo
);
    logic [127:0] r_quo, n_quo;
    logic [64:0]  r_rem, n_rem;
    logic [63:0]  r_den;
    logic [7:0]   r_cnt;
    logic         r_busy, r_done;
    logic [64:0]  w_sh;

    assign w_sh = {r_rem[63:0], r_quo[127]};

    always_comb begin
        n_quo = {r_quo[126:0], 1'b0};
        n_rem = w_sh;
        if (w_sh >= {1'b0, r_den}) begin
            n_rem = w_sh - {1'b0, r_den};
            n_quo[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
                r_cnt  <= 8'd128;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 8'd1;
                if (r_cnt == 8'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule

// ===== hw/rtl/afdv_front.sv =====
// Front part: accepts words into a two-entry queue.
// Depends on afdv_pkg.
module afdv_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  afdv_pkg::t_in_word i_word,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_valid,
    output afdv_pkg::t_in_word o_word
);
    afdv_pkg::t_in_word r_q [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_q[r_wp] <= i_word;
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_word  = r_q[r_rp];
endmodule

// ===== hw/rtl/afdv_back.sv =====
// Back part: scales, scores against stored elements, emits results.
// Depends on afdv_pkg and afdv_div.
module afdv_back #(
    parameter int MAX_ELEMENTS = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  afdv_pkg::t_in_word i_word,
    input  logic [31:0]        i_norm,
    output logic               o_pop,
    output logic               o_idle,
    output logic               o_strobe,
    output afdv_pkg::t_out_word o_result
);
    localparam int AW = $clog2(MAX_ELEMENTS);
    localparam int CW = $clog2(MAX_ELEMENTS + 1);

    afdv_pkg::t_state r_st, n_st;
    logic signed [47:0] mem_val [MAX_ELEMENTS];
    logic               mem_lab [MAX_ELEMENTS];
    logic signed [47:0] r_rd_val;
    logic               r_rd_lab;

    afdv_pkg::t_in_word r_w;
    logic [CW-1:0] r_in_tot, r_out_tot, r_idx;
    logic signed [63:0] r_in_sum, r_out_sum;
    logic [2*CW:0] r_score;
    logic r_clip;
    logic signed [47:0] r_s;
    logic signed [63:0] r_mean_in, r_mean_out;
    logic [1:0] r_phase;
    logic signed [63:0] r_fold_num, r_fold_den;
    logic signed [31:0] r_fold;
    logic r_neg;

    logic          d_go;
    logic [127:0]  d_num;
    logic [63:0]   d_den;
    logic          d_busy;
    logic          d_done;
    logic [127:0]  d_quo;

    afdv_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_go(d_go), .i_num(d_num), .i_den(d_den),
        .o_busy(d_busy), .o_done(d_done), .o_quo(d_quo)
    );

    logic [CW-1:0] w_n;
    assign w_n = r_in_tot + r_out_tot;

    logic [63:0] w_vmag;
    assign w_vmag = r_w.sample_value[31] ? 64'(-65'(r_w.sample_value))
                                          : 64'(r_w.sample_value);

    logic [63:0] w_mag_in, w_mag_out, w_an, w_ad;
    assign w_mag_in  = r_in_sum[63]  ? 64'(-r_in_sum)  : 64'(r_in_sum);
    assign w_mag_out = r_out_sum[63] ? 64'(-r_out_sum) : 64'(r_out_sum);
    assign w_an = r_fold_num[63] ? 64'(-r_fold_num) : 64'(r_fold_num);
    assign w_ad = r_fold_den[63] ? 64'(-r_fold_den) : 64'(r_fold_den);

    logic [2*CW-1:0] w_pairs;
    assign w_pairs = r_in_tot * r_out_tot;

    always_comb begin
        n_st = r_st;
        case (r_st)
            afdv_pkg::ST_IDLE:    if (i_valid) n_st = afdv_pkg::ST_SCALE;
            afdv_pkg::ST_SCALE:   if (d_done || w_n >= CW'(MAX_ELEMENTS)
                                      || w_vmag == 64'd0 || r_w.column_scale == 24'd0
                                      || r_phase == 2'd1)
                                      n_st = (w_n >= CW'(MAX_ELEMENTS))
                                          ? (r_w.last_element ? afdv_pkg::ST_MEAN
                                                              : afdv_pkg::ST_IDLE)
                                          : afdv_pkg::ST_SCAN_RD;
            afdv_pkg::ST_SCAN_RD: n_st = (r_idx == w_n) ? afdv_pkg::ST_STORE
                                                        : afdv_pkg::ST_SCAN;
            afdv_pkg::ST_SCAN:    n_st = afdv_pkg::ST_SCAN_RD;
            afdv_pkg::ST_STORE:   n_st = r_w.last_element ? afdv_pkg::ST_MEAN
                                                          : afdv_pkg::ST_IDLE;
            afdv_pkg::ST_MEAN:    if (r_phase == 2'd3) n_st = afdv_pkg::ST_FOLD;
            afdv_pkg::ST_FOLD:    if (r_phase == 2'd3) n_st = afdv_pkg::ST_AUROC;
            afdv_pkg::ST_AUROC:   if (r_phase == 2'd3) n_st = afdv_pkg::ST_EMIT;
            afdv_pkg::ST_EMIT:    n_st = afdv_pkg::ST_IDLE;
            default:              n_st = afdv_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_pop  = (r_st == afdv_pkg::ST_IDLE) && i_valid;
        o_idle = (r_st == afdv_pkg::ST_IDLE) && !i_valid;
        d_go = 1'b0;
        d_num = '0;
        d_den = '0;
        case (r_st)
            afdv_pkg::ST_SCALE: begin
                d_go  = (r_phase == 2'd0) && !d_busy && !d_done
                        && (w_n < CW'(MAX_ELEMENTS)) && (w_vmag != 64'd0)
                        && (r_w.column_scale != 24'd0);
                d_num = {32'd0, w_vmag, 32'd0};
                d_den = {40'd0, r_w.column_scale};
            end
            afdv_pkg::ST_MEAN: begin
                d_go  = ((r_phase == 2'd0 && r_in_tot != '0)
                         || (r_phase == 2'd1 && r_out_tot != '0))
                        && !d_busy && !d_done;
                d_num = (r_phase == 2'd0) ? {64'd0, w_mag_in} : {64'd0, w_mag_out};
                d_den = (r_phase == 2'd0) ? 64'(r_in_tot) : 64'(r_out_tot);
            end
            afdv_pkg::ST_FOLD: begin
                d_go  = (r_phase == 2'd0) && !d_busy && !d_done
                        && (w_an != 64'd0) && (w_ad != 64'd0);
                d_num = {48'd0, w_an, 16'd0};
                d_den = w_ad;
            end
            afdv_pkg::ST_AUROC: begin
                d_go  = (r_phase == 2'd0) && !d_busy && !d_done
                        && (r_in_tot != '0) && (r_out_tot != '0);
                d_num = 128'({r_score, 16'd0}) + 128'(w_pairs);
                d_den = 64'({w_pairs, 1'b0});
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_st == afdv_pkg::ST_SCAN_RD) begin
            r_rd_val <= mem_val[r_idx[AW-1:0]];
            r_rd_lab <= mem_lab[r_idx[AW-1:0]];
        end
        if (r_st == afdv_pkg::ST_STORE) begin
            mem_val[w_n[AW-1:0]] <= r_s;
            mem_lab[w_n[AW-1:0]] <= r_w.in_group;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= afdv_pkg::ST_IDLE;
            r_in_tot <= '0;
            r_out_tot <= '0;
            r_in_sum <= '0;
            r_out_sum <= '0;
            r_score <= '0;
            r_clip <= 1'b0;
            r_phase <= '0;
            r_idx <= '0;
            o_strobe <= 1'b0;
        end else begin
            r_st <= n_st;
            o_strobe <= 1'b0;
            case (r_st)
                afdv_pkg::ST_IDLE: begin
                    r_w <= i_word;
                    r_phase <= '0;
                    r_idx <= '0;
                end
                afdv_pkg::ST_SCALE: begin
                    if (w_n >= CW'(MAX_ELEMENTS)) begin
                        r_clip <= 1'b1;
                    end else if (w_vmag == 64'd0) begin
                        r_s <= '0;
                    end else if (r_w.column_scale == 24'd0) begin
                        r_s <= r_w.sample_value[31] ? afdv_pkg::SCALED_MIN
                                                    : afdv_pkg::SCALED_MAX;
                        r_clip <= 1'b1;
                    end else if (d_done) begin
                        if (r_w.sample_value[31]) begin
                            if (d_quo > 128'h8000_0000_0000) begin
                                r_s <= afdv_pkg::SCALED_MIN;
                                r_clip <= 1'b1;
                            end else r_s <= 48'(-d_quo[48:0]);
                        end else begin
                            if (d_quo > 128'h7FFF_FFFF_FFFF) begin
                                r_s <= afdv_pkg::SCALED_MAX;
                                r_clip <= 1'b1;
                            end else r_s <= 48'(d_quo[47:0]);
                        end
                    end
                end
                afdv_pkg::ST_SCAN: begin
                    r_idx <= r_idx + CW'(1);
                    if (r_rd_lab != r_w.in_group) begin
                        if (r_rd_val == r_s)
                            r_score <= r_score + (2*CW+1)'(1);
                        else if (r_w.in_group ? (r_s > r_rd_val) : (r_rd_val > r_s))
                            r_score <= r_score + (2*CW+1)'(2);
                    end
                end
                afdv_pkg::ST_STORE: begin
                    if (r_w.in_group) begin
                        r_in_tot <= r_in_tot + CW'(1);
                        r_in_sum <= r_in_sum + 64'(r_s);
                    end else begin
                        r_out_tot <= r_out_tot + CW'(1);
                        r_out_sum <= r_out_sum + 64'(r_s);
                    end
                end
                afdv_pkg::ST_MEAN: begin
                    if (r_phase == 2'd0) begin
                        if (r_in_tot == '0) begin
                            r_mean_in <= '0;
                            r_phase <= 2'd1;
                        end else if (d_done) begin
                            r_mean_in <= r_in_sum[63] ? 64'(-d_quo[63:0]) : d_quo[63:0];
                            r_phase <= 2'd1;
                        end
                    end else if (r_phase == 2'd1) begin
                        if (r_out_tot == '0) begin
                            r_mean_out <= '0;
                            r_phase <= 2'd2;
                        end else if (d_done) begin
                            r_mean_out <= r_out_sum[63] ? 64'(-d_quo[63:0]) : d_quo[63:0];
                            r_phase <= 2'd2;
                        end
                    end else if (r_phase == 2'd2) begin
                        r_fold_num <= r_mean_in + 64'(i_norm);
                        r_fold_den <= r_mean_out + 64'(i_norm);
                        r_phase <= 2'd3;
                    end else r_phase <= 2'd0;
                end
                afdv_pkg::ST_FOLD: begin
                    r_neg <= r_fold_num[63] != r_fold_den[63];
                    if (r_phase == 2'd0) begin
                        if (w_an == 64'd0) begin
                            r_fold <= '0;
                            r_phase <= 2'd3;
                        end else if (w_ad == 64'd0) begin
                            r_fold <= r_fold_num[63] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                            r_clip <= 1'b1;
                            r_phase <= 2'd3;
                        end else if (d_done) r_phase <= 2'd1;
                    end else if (r_phase == 2'd1) begin
                        if (r_neg) begin
                            if (d_quo > 128'h8000_0000) begin
                                r_fold <= 32'sh8000_0000;
                                r_clip <= 1'b1;
                            end else r_fold <= 32'(-d_quo[32:0]);
                        end else begin
                            if (d_quo > 128'h7FFF_FFFF) begin
                                r_fold <= 32'sh7FFF_FFFF;
                                r_clip <= 1'b1;
                            end else r_fold <= d_quo[31:0];
                        end
                        r_phase <= 2'd3;
                    end else r_phase <= 2'd0;
                end
                afdv_pkg::ST_AUROC: begin
                    if (r_phase == 2'd0) begin
                        if (r_in_tot == '0) begin
                            o_result.auroc_value <= '0;
                            r_phase <= 2'd3;
                        end else if (r_out_tot == '0) begin
                            o_result.auroc_value <= afdv_pkg::AUROC_ONE;
                            r_phase <= 2'd3;
                        end else if (d_done) begin
                            o_result.auroc_value <= d_quo[16:0];
                            r_phase <= 2'd3;
                        end
                    end else r_phase <= 2'd0;
                end
                afdv_pkg::ST_EMIT: begin
                    o_strobe <= 1'b1;
                    o_result.fold_ratio <= r_fold;
                    o_result.saturated <= r_clip;
                    r_in_tot <= '0;
                    r_out_tot <= '0;
                    r_in_sum <= '0;
                    r_out_sum <= '0;
                    r_score <= '0;
                    r_clip <= 1'b0;
                end
                default: ;
            endcase
        end
    end
endmodule
